@@ sv/srg_pkg.sv @@
package srg_pkg;

  localparam logic [2:0] OP_VALIDATE = 3'd0;
  localparam logic [2:0] OP_BEAT     = 3'd1;
  localparam logic [2:0] OP_START    = 3'd2;
  localparam logic [2:0] OP_END      = 3'd3;
  localparam logic [2:0] OP_TXSEQ    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SESSION = 2'd1;
  localparam logic [1:0] ST_SEQ     = 2'd2;
  localparam logic [1:0] ST_TTL     = 2'd3;

  localparam int unsigned AddrW = 3;
  localparam logic        RegTimeout = 1'b0;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_time;
    logic [31:0] msg_seq;
    logic [31:0] msg_stamp;
    logic [31:0] msg_ttl;
    logic [31:0] sess_ident;
    logic [7:0]  node_id;
    logic [7:0]  proto_rev;
    logic [7:0]  safety_code;
  } item_t;

  typedef struct packed {
    logic        session_on;
    logic [31:0] current_ident;
    logic [7:0]  stored_node;
    logic [7:0]  stored_version;
    logic [31:0] last_seq_ok;
    logic [31:0] last_stamp_ok;
    logic [31:0] tx_counter;
    logic [31:0] last_beat_time;
    logic [7:0]  safety_store;
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tx_number;
    logic        peer_alive;
    logic        active_flag;
    logic [7:0]  peer_safety;
    logic [7:0]  node_readout;
    logic [7:0]  version_readout;
  } result_t;

endpackage

@@ sv/srg_step.sv @@
module srg_step import srg_pkg::*; (
  input  item_t       item_i,
  input  state_t      state_i,
  input  logic [31:0] timeout_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [1:0]  status;
  logic [31:0] txn;
  logic [31:0] msg_age;
  logic [31:0] beat_age;
  state_t      nxt;

  assign msg_age = item_i.now_time - item_i.msg_stamp;

  always_comb begin
    nxt    = state_i;
    status = ST_OK;
    txn    = '0;
    unique case (item_i.func)
      OP_VALIDATE: begin
        if (!state_i.session_on || item_i.sess_ident != state_i.current_ident) begin
          status = ST_SESSION;
        end else if (item_i.msg_seq <= state_i.last_seq_ok ||
                     item_i.msg_stamp < state_i.last_stamp_ok) begin
          status = ST_SEQ;
        end else if (item_i.msg_ttl != '0 && msg_age > item_i.msg_ttl) begin
          status = ST_TTL;
        end else begin
          nxt.last_seq_ok   = item_i.msg_seq;
          nxt.last_stamp_ok = item_i.msg_stamp;
        end
      end
      OP_BEAT: begin
        nxt.last_beat_time = item_i.now_time;
        nxt.safety_store   = item_i.safety_code;
      end
      OP_START: begin
        nxt.current_ident  = item_i.sess_ident;
        nxt.stored_node    = item_i.node_id;
        nxt.stored_version = item_i.proto_rev;
        nxt.last_seq_ok    = '0;
        nxt.last_stamp_ok  = '0;
        nxt.tx_counter     = '0;
        nxt.session_on     = 1'b1;
      end
      OP_END: begin
        nxt.session_on    = 1'b0;
        nxt.current_ident = '0;
      end
      OP_TXSEQ: begin
        nxt.tx_counter = state_i.tx_counter + 32'd1;
        txn            = nxt.tx_counter;
      end
      default: begin
      end
    endcase
  end

  assign beat_age = item_i.now_time - nxt.last_beat_time;

  assign state_o = nxt;

  always_comb begin
    result_o.status          = status;
    result_o.tx_number       = txn;
    result_o.peer_alive      = nxt.session_on && (beat_age < timeout_i);
    result_o.active_flag     = nxt.session_on;
    result_o.peer_safety     = nxt.safety_store;
    result_o.node_readout    = nxt.stored_node;
    result_o.version_readout = nxt.stored_version;
  end

endmodule

@@ sv/session_replay_guard_top.sv @@
// Session replay and liveness guard.
// Requests arrive on the input channel (in_valid_i, in_stall_o) with an
// operation code and message fields; each request yields exactly one result
// on the output channel (out_valid_o, out_stall_i) in request order.
// A request is captured in an input register, evaluated against the session
// state combinationally, and written to the result register together with the
// state update; the result register takes it when it is empty or the receiver
// does not stall, and out_valid_o then shows the result.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single evaluation stage between the input register and the result register.
// When the receiver stalls, the result register holds its value and one
// further request may wait in the input register; only then is in_stall_o
// raised.
// The heartbeat timeout is written through the APB port at byte address 0; the user
// must do so only while no request is in flight, which the block does not enforce.
// Reset clears the session state, the timeout and the valid flags of both
// pipeline registers.
module session_replay_guard_top import srg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        now_time_i,
  input  logic [31:0]        msg_seq_i,
  input  logic [31:0]        msg_stamp_i,
  input  logic [31:0]        msg_ttl_i,
  input  logic [31:0]        sess_ident_i,
  input  logic [7:0]         node_id_i,
  input  logic [7:0]         proto_rev_i,
  input  logic [7:0]         safety_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        tx_number_o,
  output logic               peer_alive_o,
  output logic               active_flag_o,
  output logic [7:0]         peer_safety_o,
  output logic [7:0]         node_readout_o,
  output logic [7:0]         version_readout_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        in_valid_q;
  item_t       in_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     res_d;
  state_t      state_q;
  state_t      state_d;
  logic [31:0] timeout_q;
  logic        advance;
  logic        in_take;

  assign pready  = 1'b1;
  assign prdata  = (paddr[AddrW-1] == RegTimeout) ? timeout_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[AddrW-1] == RegTimeout) begin
      timeout_q <= pwdata;
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.func         <= func_i;
      in_q.now_time     <= now_time_i;
      in_q.msg_seq      <= msg_seq_i;
      in_q.msg_stamp    <= msg_stamp_i;
      in_q.msg_ttl      <= msg_ttl_i;
      in_q.sess_ident   <= sess_ident_i;
      in_q.node_id      <= node_id_i;
      in_q.proto_rev    <= proto_rev_i;
      in_q.safety_code  <= safety_code_i;
    end
  end

  srg_step u_step (
    .item_i    (in_q),
    .state_i   (state_q),
    .timeout_i (timeout_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign tx_number_o       = out_q.tx_number;
  assign peer_alive_o      = out_q.peer_alive;
  assign active_flag_o     = out_q.active_flag;
  assign peer_safety_o     = out_q.peer_safety;
  assign node_readout_o    = out_q.node_readout;
  assign version_readout_o = out_q.version_readout;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a waiting request and a held result");

  a_alive_needs_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.active_flag) |-> !out_q.peer_alive)
    else $error("peer reported alive without an active session");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.func == OP_START) |=> (state_q.session_on && state_q.tx_counter == '0))
    else $error("session start did not open a fresh session");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.func == OP_END) |=> (!state_q.session_on && state_q.current_ident == '0))
    else $error("session end did not close the session");

endmodule
